// ===== sv/pid_deadband_bridge_drive_assert.svh =====
// Assertion helpers for the PID drive RTL.
`ifndef PID_DEADBAND_BRIDGE_DRIVE_ASSERT_SVH
`define PID_DEADBAND_BRIDGE_DRIVE_ASSERT_SVH

// Check that a condition implies another in the same cycle.
`define PIDB_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that a condition implies another in the next cycle.
`define PIDB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/pidb_pkg.sv =====
`timescale 1ns / 1ps
package pidb_pkg;

   localparam int DRIVE_LIMIT    = 100;
   localparam int GAIN_SCALE     = 10000;
   localparam int INTEGRAL_SCALE = DRIVE_LIMIT * GAIN_SCALE;

   localparam int SAMPLE_W   = 16;
   localparam int GAIN_W     = 16;
   localparam int FRIC_W     = 7;
   localparam int CSR_DATA_W = 16;
   localparam int CSR_IDX_W  = 3;

   localparam int ERR_W    = SAMPLE_W + 1;
   localparam int DERIV_W  = ERR_W + 1;
   localparam int ISUM_W   = 32;
   localparam int LIMIT_W  = 20;
   localparam int PROD_P_W = ERR_W + GAIN_W + 1;
   localparam int PROD_D_W = DERIV_W + GAIN_W + 1;
   localparam int PROD_I_W = ISUM_W + GAIN_W + 1;
   localparam int SUM_W    = PROD_I_W + 1;

   // From this magnitude up the quotient already exceeds the drive limit.
   localparam int SAT_THRESH = (DRIVE_LIMIT + 1) * GAIN_SCALE;
   localparam int MAG_W      = 20;
   localparam int RECIP_SHIFT = 37;
   localparam int RECIP_W     = 24;
   localparam longint unsigned RECIP_FULL =
      ((64'd1 << RECIP_SHIFT) + longint'(GAIN_SCALE) - 64'd1) / longint'(GAIN_SCALE);
   localparam logic [RECIP_W-1:0] RECIP_VALUE = RECIP_W'(RECIP_FULL);
   localparam int QUOT_W  = 7;
   localparam int RAW_W   = QUOT_W + 1;
   localparam int DRIVE_W = 8;

   localparam int NSTAGE = 6;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_TARGET_VALUE    = 3'd0,
      REG_GAIN_P          = 3'd1,
      REG_GAIN_I          = 3'd2,
      REG_GAIN_D          = 3'd3,
      REG_FRICTION_OFFSET = 3'd4,
      REG_DEADBAND_WIDTH  = 3'd5
   } csr_reg_type;

   typedef struct packed {
      logic               busy;
      logic [LIMIT_W-1:0] limit;
   } lim_stat_type;

endpackage

// ===== sv/pidb_limit_div.sv =====
`timescale 1ns / 1ps
// Restoring divider: integral limit = INTEGRAL_SCALE / divisor, one bit per cycle.
module pidb_limit_div import pidb_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [GAIN_W-1:0] divisor,
   output lim_stat_type      stat
);

   localparam int CNT_W = $clog2(LIMIT_W);

   logic               busy_ff, busy_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [LIMIT_W-1:0] num_ff, num_in;
   logic [GAIN_W-1:0]  rem_ff, rem_in;
   logic [LIMIT_W-1:0] quo_ff, quo_in;
   logic [GAIN_W-1:0]  den_ff, den_in;

   logic [GAIN_W:0] trial;
   logic [GAIN_W:0] diff;
   logic            fits;

   always_comb begin
      trial = {rem_ff, num_ff[LIMIT_W-1]};
      diff  = trial - {1'b0, den_ff};
      fits  = trial >= {1'b0, den_ff};

      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;

      if (start) begin
         busy_in = divisor != '0;
         cnt_in  = '0;
         num_in  = LIMIT_W'(INTEGRAL_SCALE);
         rem_in  = '0;
         quo_in  = '0;
         den_in  = divisor;
      end else if (busy_ff) begin
         num_in = {num_ff[LIMIT_W-2:0], 1'b0};
         rem_in = fits ? diff[GAIN_W-1:0] : trial[GAIN_W-1:0];
         quo_in = {quo_ff[LIMIT_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(LIMIT_W - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign stat.busy  = busy_ff;
   assign stat.limit = quo_ff;

endmodule

// ===== sv/pid_deadband_bridge_drive.sv =====
`timescale 1ns / 1ps
// PID drive for an H-bridge, with an error deadband and a clamped integral.
// Request channel (req_valid/req_ready): one upper and one lower sensor sample.
// Response channel (rsp_valid/rsp_ready): signed drive in -100..100 and the two
// bridge pin levels. Every request yields exactly one response, in order.
// Configuration (csr_we/csr_index/csr_wdata): six registers, written with no
// read-back. A nonzero write to the integral gain starts a restoring divider
// that computes the integral limit; req_ready stays low meanwhile.
// Throughput: one request per cycle unless a stall or a divider run holds
// req_ready low. A request passes through six pipeline registers. The
// integral and previous-error state update in the first stage, so the
// recurrence closes within that stage; products, sum, magnitude, reciprocal
// scaling and drive shaping follow in their own stages.
// Stall: each stage advances when it is empty or the next one advances; a
// stalled response holds while bubbles in earlier stages keep filling.
// Reset: the configuration and valid registers, the integral, previous error
// and pins clear to zero; the block takes requests as soon as reset ends.
`include "pid_deadband_bridge_drive_assert.svh"
module pid_deadband_bridge_drive import pidb_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [SAMPLE_W-1:0]        req_upper_sample,
   input  logic [SAMPLE_W-1:0]        req_lower_sample,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [DRIVE_W-1:0]  rsp_drive,
   output logic                       rsp_bridge_left,
   output logic                       rsp_bridge_right,
   input  logic                       csr_we,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_wdata
);

   // configuration registers
   logic signed [SAMPLE_W-1:0] tgt_ff;
   logic [GAIN_W-1:0]          kp_ff, ki_ff, kd_ff;
   logic [FRIC_W-1:0]          fric_ff;
   logic [GAIN_W-1:0]          band_ff;

   lim_stat_type lim;
   logic         lim_start;

   // pipeline control
   logic [NSTAGE:1] vld_ff, vld_in;
   logic [NSTAGE:1] adv;
   logic            req_accept;

   // controller state
   logic signed [ISUM_W-1:0] isum_ff, isum_in;
   logic signed [ERR_W-1:0]  prev_err_ff, prev_err_in;
   logic                     pin_left_ff, pin_left_in;
   logic                     pin_right_ff, pin_right_in;

   // stage registers
   logic signed [DERIV_W-1:0]  s1_deriv_ff;
   logic                       s1_dead_ff;
   logic signed [PROD_P_W-1:0] s2_p_ff;
   logic signed [PROD_D_W-1:0] s2_d_ff;
   logic signed [PROD_I_W-1:0] s2_i_ff;
   logic                       s2_dead_ff;
   logic signed [SUM_W-1:0]    s3_sum_ff;
   logic                       s3_dead_ff;
   logic                       s4_neg_ff, s4_big_ff, s4_dead_ff;
   logic [MAG_W-1:0]           s4_mag_ff;
   logic                       s5_neg_ff, s5_dead_ff;
   logic [QUOT_W-1:0]          s5_quot_ff;
   logic signed [DRIVE_W-1:0]  drive_ff, drive_in;

   // ---------------------------------------------------------------------
   // Configuration writes; a gain_i write also restarts the limit divider.
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         tgt_ff  <= '0;
         kp_ff   <= '0;
         ki_ff   <= '0;
         kd_ff   <= '0;
         fric_ff <= '0;
         band_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            REG_TARGET_VALUE:    tgt_ff  <= signed'(csr_wdata[SAMPLE_W-1:0]);
            REG_GAIN_P:          kp_ff   <= csr_wdata[GAIN_W-1:0];
            REG_GAIN_I:          ki_ff   <= csr_wdata[GAIN_W-1:0];
            REG_GAIN_D:          kd_ff   <= csr_wdata[GAIN_W-1:0];
            REG_FRICTION_OFFSET: fric_ff <= csr_wdata[FRIC_W-1:0];
            REG_DEADBAND_WIDTH:  band_ff <= csr_wdata[GAIN_W-1:0];
            default: begin
               // unknown index: drop the write
            end
         endcase
      end
   end

   assign lim_start = csr_we && (csr_index == REG_GAIN_I);

   pidb_limit_div u_limit_div (
      .clock   (clock),
      .reset   (reset),
      .start   (lim_start),
      .divisor (csr_wdata[GAIN_W-1:0]),
      .stat    (lim)
   );

   // ---------------------------------------------------------------------
   // Flow control: a stage advances when empty or when its successor does.
   // ---------------------------------------------------------------------
   always_comb begin
      adv[NSTAGE] = !vld_ff[NSTAGE] || rsp_ready;
      for (int k = NSTAGE - 1; k >= 1; k--) begin
         adv[k] = !vld_ff[k] || adv[k+1];
      end
   end

   assign req_ready  = adv[1] && !lim.busy;
   assign req_accept = req_valid && req_ready;

   always_comb begin
      vld_in[1] = adv[1] ? req_accept : vld_ff[1];
      for (int k = 2; k <= NSTAGE; k++) begin
         vld_in[k] = adv[k] ? vld_ff[k-1] : vld_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 1: error, deadband, integral and derivative. The state updates
   // only on an accepted request, so while stage 1 holds an item the integral
   // and previous-error registers are that item's values.
   // ---------------------------------------------------------------------
   logic signed [SAMPLE_W-1:0] meas;
   logic signed [ERR_W-1:0]    err, err_z;
   logic signed [ERR_W:0]      err_x, half_x;
   logic                       in_band;
   logic signed [ISUM_W:0]     acc_sum, acc_hi, acc_lo;
   logic signed [DERIV_W-1:0]  deriv;

   always_comb begin
      meas    = signed'(SAMPLE_W'(req_upper_sample - req_lower_sample));
      err     = ERR_W'(tgt_ff) - ERR_W'(meas);
      err_x   = (ERR_W+1)'(err);
      half_x  = signed'({3'b000, band_ff[GAIN_W-1:1]});
      in_band = (err_x <= half_x) && (err_x >= -half_x);
      err_z   = in_band ? '0 : err;

      acc_sum = (ISUM_W+1)'(isum_ff) + (ISUM_W+1)'(err_z);
      if (ki_ff != '0) begin
         acc_hi = signed'((ISUM_W+1)'(lim.limit));
         acc_lo = -acc_hi;
      end else begin
         acc_hi = signed'({2'b00, {(ISUM_W-1){1'b1}}});
         acc_lo = signed'({2'b11, {(ISUM_W-1){1'b0}}});
      end

      isum_in = isum_ff;
      if (acc_sum > acc_hi) begin
         isum_in = acc_hi[ISUM_W-1:0];
      end else if (acc_sum < acc_lo) begin
         isum_in = acc_lo[ISUM_W-1:0];
      end else begin
         isum_in = acc_sum[ISUM_W-1:0];
      end

      deriv       = DERIV_W'(err_z) - DERIV_W'(prev_err_ff);
      prev_err_in = err_z;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         isum_ff     <= '0;
         prev_err_ff <= '0;
      end else if (req_accept) begin
         isum_ff     <= isum_in;
         prev_err_ff <= prev_err_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         s1_deriv_ff <= deriv;
         s1_dead_ff  <= in_band;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 2: the three gain products.
   // ---------------------------------------------------------------------
   logic signed [GAIN_W:0] kp_s, ki_s, kd_s;

   always_comb begin
      kp_s = signed'({1'b0, kp_ff});
      ki_s = signed'({1'b0, ki_ff});
      kd_s = signed'({1'b0, kd_ff});
   end

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         s2_p_ff    <= PROD_P_W'(kp_s) * PROD_P_W'(prev_err_ff);
         s2_d_ff    <= PROD_D_W'(kd_s) * PROD_D_W'(s1_deriv_ff);
         s2_i_ff    <= PROD_I_W'(ki_s) * PROD_I_W'(isum_ff);
         s2_dead_ff <= s1_dead_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 3: sum of the terms.
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (adv[3]) begin
         s3_sum_ff  <= SUM_W'(s2_p_ff) + SUM_W'(s2_d_ff) + SUM_W'(s2_i_ff);
         s3_dead_ff <= s2_dead_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 4: sign and magnitude. Divide the magnitude, so the quotient
   // truncates toward zero; flag magnitudes that saturate the drive anyway.
   // ---------------------------------------------------------------------
   logic [SUM_W-1:0] mag_full;

   always_comb begin
      mag_full = s3_sum_ff[SUM_W-1] ? unsigned'(-s3_sum_ff) : unsigned'(s3_sum_ff);
   end

   always_ff @(posedge clock) begin
      if (adv[4]) begin
         s4_neg_ff  <= s3_sum_ff[SUM_W-1];
         s4_big_ff  <= mag_full >= SUM_W'(SAT_THRESH);
         s4_mag_ff  <= mag_full[MAG_W-1:0];
         s4_dead_ff <= s3_dead_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 5: divide by the gain scale through a reciprocal multiply; exact
   // for every magnitude below the saturation threshold.
   // ---------------------------------------------------------------------
   logic [MAG_W+RECIP_W-1:0] rcp_prod;

   always_comb begin
      rcp_prod = (MAG_W+RECIP_W)'(s4_mag_ff) * (MAG_W+RECIP_W)'(RECIP_VALUE);
   end

   always_ff @(posedge clock) begin
      if (adv[5]) begin
         s5_quot_ff <= s4_big_ff ? QUOT_W'(DRIVE_LIMIT + 1)
                                 : rcp_prod[RECIP_SHIFT +: QUOT_W];
         s5_neg_ff  <= s4_neg_ff;
         s5_dead_ff <= s4_dead_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 6: friction offset, saturation and bridge pins. The pin registers
   // double as the response pins; the deadband clears them, a nonzero drive
   // sets them by its sign, and a zero drive keeps them.
   // ---------------------------------------------------------------------
   logic signed [RAW_W-1:0] q_x, raw;
   logic signed [RAW_W:0]   drv_wide;
   logic                    raw_pos;

   always_comb begin
      q_x     = signed'({1'b0, s5_quot_ff});
      raw     = s5_neg_ff ? -q_x : q_x;
      raw_pos = !s5_neg_ff && (s5_quot_ff != '0);
      if (raw_pos) begin
         drv_wide = (RAW_W+1)'(raw) + (RAW_W+1)'(signed'({1'b0, fric_ff}));
      end else begin
         drv_wide = (RAW_W+1)'(raw) - (RAW_W+1)'(signed'({1'b0, fric_ff}));
      end

      if (drv_wide > (RAW_W+1)'(DRIVE_LIMIT)) begin
         drive_in = DRIVE_W'(DRIVE_LIMIT);
      end else if (drv_wide < -(RAW_W+1)'(DRIVE_LIMIT)) begin
         drive_in = -DRIVE_W'(DRIVE_LIMIT);
      end else begin
         drive_in = DRIVE_W'(drv_wide);
      end

      pin_left_in  = s5_dead_ff ? 1'b0 : pin_left_ff;
      pin_right_in = s5_dead_ff ? 1'b0 : pin_right_ff;
      if (drive_in < 0) begin
         pin_left_in  = 1'b1;
         pin_right_in = 1'b0;
      end else if (drive_in > 0) begin
         pin_left_in  = 1'b0;
         pin_right_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pin_left_ff  <= 1'b0;
         pin_right_ff <= 1'b0;
      end else if (adv[NSTAGE] && vld_ff[NSTAGE-1]) begin
         pin_left_ff  <= pin_left_in;
         pin_right_ff <= pin_right_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[NSTAGE]) begin
         drive_ff <= drive_in;
      end
   end

   assign rsp_valid        = vld_ff[NSTAGE];
   assign rsp_drive        = drive_ff;
   assign rsp_bridge_left  = pin_left_ff;
   assign rsp_bridge_right = pin_right_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   `PIDB_ASSERT_SAME(a_drive_range, clock, reset, rsp_valid,
      (rsp_drive <= 8'sd100) && (rsp_drive >= -8'sd100), "drive out of range")

   `PIDB_ASSERT_SAME(a_pins_exclusive, clock, reset, rsp_valid,
      !(rsp_bridge_left && rsp_bridge_right), "both bridge pins on")

   `PIDB_ASSERT_SAME(a_pins_follow_drive, clock, reset, rsp_valid && (rsp_drive != '0),
      (rsp_bridge_left != rsp_bridge_right) && (rsp_bridge_left == rsp_drive[DRIVE_W-1]),
      "pins disagree with drive sign")

   `PIDB_ASSERT_NEXT(a_limit_blocks_req, clock, reset,
      csr_we && (csr_index == REG_GAIN_I) && (csr_wdata[GAIN_W-1:0] != '0),
      !req_ready, "request taken while integral limit is computed")

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
   import pidb_pkg::*;

   // Unused register indexes: writes to these must leave every register alone.
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_A = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_B = 3'd7;

   // Length of each unbroken full-error burst.
   localparam int     SOAK_ITEMS   = 30;
   localparam int     PHASE_COUNT  = 9;
   localparam int     PHASE_ITEMS  = 90;
   localparam int     IDLE_PERCENT = 11;
   localparam longint SUM_MIN      = -64'sd2147483648;
   localparam longint SUM_MAX      = 64'sd2147483647;

   // One bridge command as it leaves the block.
   typedef struct packed {
      logic signed [DRIVE_W-1:0] drive;
      logic                      left;
      logic                      right;
   } bridge_cmd_type;

   logic                      clock            = 1'b0;
   logic                      reset            = 1'b1;
   logic                      req_valid        = 1'b0;
   logic                      req_ready;
   logic [SAMPLE_W-1:0]       req_upper_sample = '0;
   logic [SAMPLE_W-1:0]       req_lower_sample = '0;
   logic                      rsp_valid;
   logic                      rsp_ready        = 1'b0;
   logic signed [DRIVE_W-1:0] rsp_drive;
   logic                      rsp_bridge_left;
   logic                      rsp_bridge_right;
   logic                      csr_we           = 1'b0;
   logic [CSR_IDX_W-1:0]      csr_index        = '0;
   logic [CSR_DATA_W-1:0]     csr_wdata        = '0;

   // Controller copy: registers as the block holds them after each write.
   logic signed [SAMPLE_W-1:0] target_sp  = '0;
   logic [GAIN_W-1:0]          kp         = '0;
   logic [GAIN_W-1:0]          ki         = '0;
   logic [GAIN_W-1:0]          kd         = '0;
   logic [FRIC_W-1:0]          fric_ofs   = '0;
   logic [SAMPLE_W-1:0]        dead_width = '0;
   // Controller copy: loop state carried from one request to the next.
   longint                     integ      = 0;
   longint                     last_err   = 0;
   longint                     integ_cap  = 0;
   logic                       pin_l      = 1'b0;
   logic                       pin_r      = 1'b0;

   bridge_cmd_type pending_cmds[$];
   int             fail_count = 0;
   bit             burst_mode = 1'b0;

   pid_deadband_bridge_drive i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_upper_sample (req_upper_sample),
      .req_lower_sample (req_lower_sample),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_drive        (rsp_drive),
      .rsp_bridge_left  (rsp_bridge_left),
      .rsp_bridge_right (rsp_bridge_right),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic longint clamp_long(input longint v, input longint lo, input longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   // Advance the controller copy by one sample pair and return the command it drives.
   function automatic bridge_cmd_type predict_bridge_cmd(input logic [SAMPLE_W-1:0] upper,
                                                         input logic [SAMPLE_W-1:0] lower);
      logic signed [SAMPLE_W-1:0] meas;
      longint                     err;
      longint                     half;
      longint                     deriv;
      longint                     raw;
      longint                     drv;
      bridge_cmd_type             cmd;
      // The difference wraps to 16 bits before it is read as signed.
      meas = upper - lower;
      err  = longint'(target_sp) - longint'(meas);
      half = longint'(dead_width >> 1);
      // Inside the deadband: zero the error and release both pins.
      if (err >= -half && err <= half) begin
         err   = 0;
         pin_l = 1'b0;
         pin_r = 1'b0;
      end
      integ = integ + err;
      if (ki != '0) begin
         integ = clamp_long(integ, -integ_cap, integ_cap);
      end else begin
         integ = clamp_long(integ, SUM_MIN, SUM_MAX);
      end
      deriv    = err - last_err;
      last_err = err;
      raw = (longint'(kp) * err + longint'(kd) * deriv + longint'(ki) * integ)
            / longint'(GAIN_SCALE);
      // Friction pushes a positive drive up and anything else, zero too, down.
      if (raw > 0) begin
         drv = raw + longint'(fric_ofs);
      end else begin
         drv = raw - longint'(fric_ofs);
      end
      drv = clamp_long(drv, -DRIVE_LIMIT, DRIVE_LIMIT);
      // A zero drive keeps the pins where they were.
      if (drv < 0) begin
         pin_l = 1'b1;
         pin_r = 1'b0;
      end else if (drv > 0) begin
         pin_l = 1'b0;
         pin_r = 1'b1;
      end
      cmd.drive = DRIVE_W'(drv);
      cmd.left  = pin_l;
      cmd.right = pin_r;
      return cmd;
   endfunction

   // Offer one sample pair; hold it until accepted, then queue its expected command.
   // Valid is left high so back-to-back requests never toggle it within a step.
   task automatic send_sample_pair(input logic [SAMPLE_W-1:0] upper,
                                   input logic [SAMPLE_W-1:0] lower);
      if (!burst_mode) begin
         while ($urandom_range(0, 99) < IDLE_PERCENT) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid        <= 1'b1;
      req_upper_sample <= upper;
      req_lower_sample <= lower;
      do @(posedge clock); while (!req_ready);
      pending_cmds.push_back(predict_bridge_cmd(upper, lower));
   endtask

   // Drop valid and wait until every queued command has come back.
   task automatic drain_responses();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_cmds.size() != 0) @(posedge clock);
   endtask

   // Write one register while the block is idle, then mirror it in the controller copy.
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      drain_responses();
      // Hold off while the integral-limit divider from an earlier gain write runs.
      while (!req_ready) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         REG_TARGET_VALUE:    target_sp  = data;
         REG_GAIN_P:          kp         = data;
         REG_GAIN_I: begin
            ki        = data;
            integ_cap = (data != '0) ? longint'(INTEGRAL_SCALE) / longint'(data) : 0;
         end
         REG_GAIN_D:          kd         = data;
         REG_FRICTION_OFFSET: fric_ofs   = data[FRIC_W-1:0];
         REG_DEADBAND_WIDTH:  dead_width = data;
         default: ;
      endcase
      @(posedge clock);
   endtask

   // Load every register; the integral gain goes last since it starts the divider.
   task automatic load_controller(input logic [CSR_DATA_W-1:0] target,
                                  input logic [CSR_DATA_W-1:0] gp,
                                  input logic [CSR_DATA_W-1:0] gd,
                                  input logic [CSR_DATA_W-1:0] fric,
                                  input logic [CSR_DATA_W-1:0] dead,
                                  input logic [CSR_DATA_W-1:0] gi);
      write_csr(REG_TARGET_VALUE, target);
      write_csr(REG_GAIN_P, gp);
      write_csr(REG_GAIN_D, gd);
      write_csr(REG_FRICTION_OFFSET, fric);
      write_csr(REG_DEADBAND_WIDTH, dead);
      write_csr(REG_GAIN_I, gi);
   endtask

   function automatic logic [CSR_DATA_W-1:0] pick_gain();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return 16'hFFFF;
         2, 3:    return CSR_DATA_W'($urandom_range(1, 300));
         4:       return CSR_DATA_W'($urandom_range(1, 5000));
         default: return CSR_DATA_W'($urandom);
      endcase
   endfunction

   function automatic logic [SAMPLE_W-1:0] pick_corner();
      case ($urandom_range(0, 3))
         0:       return 16'h0000;
         1:       return 16'h7FFF;
         2:       return 16'h8000;
         default: return 16'hFFFF;
      endcase
   endfunction

   // Mostly pairs whose measurement sits near the setpoint, some corners, some pure noise.
   function automatic void pick_pair(output logic [SAMPLE_W-1:0] upper,
                                     output logic [SAMPLE_W-1:0] lower);
      int e;
      upper = SAMPLE_W'($urandom);
      case ($urandom_range(0, 9))
         0, 1: lower = SAMPLE_W'($urandom);
         2: begin
            upper = pick_corner();
            lower = pick_corner();
         end
         default: begin
            e     = int'($urandom_range(0, 4000)) - 2000;
            lower = upper - SAMPLE_W'(int'(target_sp) - e);
         end
      endcase
   endfunction

   // Response side: check each accepted command, then decide next cycle's ready.
   always @(posedge clock) begin : rsp_check
      bridge_cmd_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_cmds.size() == 0) begin
            fail_count++;
            $error("response with none expected: drive %0d", rsp_drive);
         end else begin
            want = pending_cmds.pop_front();
            if (rsp_drive !== want.drive) begin
               fail_count++;
               $error("drive: expected %0d, actual %0d", $signed(want.drive), rsp_drive);
            end
            if (rsp_bridge_left !== want.left) begin
               fail_count++;
               $error("bridge_left: expected %0b, actual %0b", want.left, rsp_bridge_left);
            end
            if (rsp_bridge_right !== want.right) begin
               fail_count++;
               $error("bridge_right: expected %0b, actual %0b", want.right, rsp_bridge_right);
            end
         end
      end
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= burst_mode || ($urandom_range(0, 99) >= IDLE_PERCENT);
      end
   end

   // All registers at zero: drive stays zero, pins follow only the deadband clear.
   task automatic test_reset_state();
      send_sample_pair(16'h0000, 16'h0000);
      send_sample_pair(16'hFFFF, 16'h0000);
      send_sample_pair(16'h0000, 16'hFFFF);
      send_sample_pair(16'h8000, 16'h7FFF);
      send_sample_pair(16'h7FFF, 16'h8000);
   endtask

   // Writes to unused indexes must not land in any register.
   task automatic test_spare_index();
      write_csr(REG_SPARE_A, 16'hFFFF);
      write_csr(REG_SPARE_B, 16'hFFFF);
      send_sample_pair(16'h8000, 16'h0000);
      send_sample_pair(16'h1234, 16'h1234);
   endtask

   // Full-scale errors with maximum and unit proportional gain.
   task automatic test_proportional_limits();
      load_controller(16'h7FFF, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      send_sample_pair(16'h8000, 16'h0000);
      write_csr(REG_TARGET_VALUE, 16'h8000);
      send_sample_pair(16'h7FFF, 16'h0000);
      send_sample_pair(16'hFFFF, 16'hFFFF);
      write_csr(REG_GAIN_P, 16'h0001);
      write_csr(REG_TARGET_VALUE, 16'h7FFF);
      send_sample_pair(16'h8000, 16'h0000);
   endtask

   // Friction on a zero raw drive, above-range offsets, and small drives both ways.
   task automatic test_friction();
      write_csr(REG_TARGET_VALUE, 16'h0000);
      write_csr(REG_FRICTION_OFFSET, 16'd100);
      send_sample_pair(16'h2222, 16'h2222);
      // Upper data bits are dropped, leaving the largest offset the field holds.
      write_csr(REG_FRICTION_OFFSET, 16'hFFFF);
      send_sample_pair(16'h0000, 16'd10000);
      write_csr(REG_FRICTION_OFFSET, 16'd5);
      send_sample_pair(16'h0000, 16'd10000);
      send_sample_pair(16'd10000, 16'h0000);
   endtask

   // Deadband edges, the widest band, and a zero drive that must keep the pins.
   task automatic test_deadband();
      load_controller(16'h0000, 16'd100, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000);
      send_sample_pair(16'h8000, 16'h0000);
      send_sample_pair(16'h7FFF, 16'h0000);
      send_sample_pair(16'h0000, 16'h8000);
      write_csr(REG_DEADBAND_WIDTH, 16'h0000);
      send_sample_pair(16'h0000, 16'h0000);
      send_sample_pair(16'h0001, 16'h0000);
      write_csr(REG_DEADBAND_WIDTH, 16'h0003);
      send_sample_pair(16'h0001, 16'h0000);
      send_sample_pair(16'h0000, 16'h0002);
   endtask

   // Widest derivative swings, with unit and maximum derivative gain.
   task automatic test_derivative();
      load_controller(16'h7FFF, 16'h0000, 16'h0001, 16'h0000, 16'h0000, 16'h0000);
      send_sample_pair(16'h8000, 16'h0000);
      write_csr(REG_TARGET_VALUE, 16'h8000);
      send_sample_pair(16'h7FFF, 16'h0000);
      write_csr(REG_GAIN_D, 16'hFFFF);
      send_sample_pair(16'h7FFF, 16'h0000);
      write_csr(REG_TARGET_VALUE, 16'h7FFF);
      send_sample_pair(16'h8000, 16'h0000);
   endtask

   // Integral clamp from the smallest limit up; the stored sum is clamped on the next step.
   task automatic test_integral_clamp();
      load_controller(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF);
      send_sample_pair(16'h0000, 16'd10);
      send_sample_pair(16'd10, 16'h0000);
      send_sample_pair(16'd10, 16'h0000);
      write_csr(REG_GAIN_I, 16'd30);
      send_sample_pair(16'h8000, 16'h0000);
      write_csr(REG_GAIN_I, 16'h0001);
      send_sample_pair(16'h0000, 16'h7FFF);
   endtask

   // Unbroken full-error bursts with no idling on either side while the integral
   // runs unlimited; a unit gain then pulls the large sum into its clamp.
   task automatic test_integral_burst();
      load_controller(16'h7FFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      burst_mode = 1'b1;
      for (int n = 0; n < SOAK_ITEMS; n++) send_sample_pair(16'h8000, 16'h0000);
      write_csr(REG_GAIN_I, 16'h0001);
      send_sample_pair(16'h8000, 16'h0000);
      write_csr(REG_GAIN_I, 16'h0000);
      write_csr(REG_TARGET_VALUE, 16'h8000);
      for (int n = 0; n < SOAK_ITEMS; n++) send_sample_pair(16'h7FFF, 16'h0000);
      write_csr(REG_GAIN_I, 16'h0001);
      send_sample_pair(16'h7FFF, 16'h0000);
      burst_mode = 1'b0;
   endtask

   // Random phases: all-high and all-low register sets first, then random ones.
   task automatic test_random_phases();
      logic [SAMPLE_W-1:0]   upper;
      logic [SAMPLE_W-1:0]   lower;
      logic [CSR_DATA_W-1:0] fric;
      logic [CSR_DATA_W-1:0] dead;
      for (int p = 0; p < PHASE_COUNT; p++) begin
         if (p == 0) begin
            load_controller(16'h7FFF, 16'hFFFF, 16'hFFFF, 16'h007F, 16'hFFFF, 16'hFFFF);
         end else if (p == 1) begin
            load_controller(16'h8000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
         end else begin
            // Random upper data bits on the offset write must be ignored.
            fric = (CSR_DATA_W'($urandom) & 16'hFF80) | CSR_DATA_W'($urandom_range(0, 127));
            case ($urandom_range(0, 3))
               0:       dead = '0;
               1:       dead = 16'hFFFF;
               default: dead = CSR_DATA_W'($urandom_range(0, 4000));
            endcase
            load_controller(CSR_DATA_W'($urandom), pick_gain(), pick_gain(), fric, dead,
                            pick_gain());
         end
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // Pause the sender once until the pipeline has emptied completely.
            if (p == 4 && n == PHASE_ITEMS / 2) drain_responses();
            pick_pair(upper, lower);
            send_sample_pair(upper, lower);
         end
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_state();
      test_spare_index();
      test_proportional_limits();
      test_friction();
      test_deadband();
      test_derivative();
      test_integral_clamp();
      test_integral_burst();
      test_random_phases();

      // Let the last commands out, then wait on for stray responses.
      drain_responses();
      repeat (4 * NSTAGE) @(posedge clock);
      if (fail_count == 0 && pending_cmds.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // Guard against a hung handshake: far beyond the slowest legal run.
   initial begin
      #2_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule

// ===== pid_deadband_bridge_drive.f =====
+incdir+sv
sv/pidb_pkg.sv
sv/pidb_limit_div.sv
sv/pid_deadband_bridge_drive.sv
tb/testbench.sv
